@@ src/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and helpers for the JSON string unescape block: result kinds,
// result groups and the UTF-8 encoding of one code point.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MaxRes = 4;
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int IdxW   = $clog2(MaxRes);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    MODE_IDLE      = 7'b0000001,
    MODE_STRING    = 7'b0000010,
    MODE_ESCAPE    = 7'b0000100,
    MODE_HEX_FIRST = 7'b0001000,
    MODE_HI_WAIT   = 7'b0010000,
    MODE_HI_BSLASH = 7'b0100000,
    MODE_HEX_LOW   = 7'b1000000
  } mode_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]         cnt;
    res_t [MaxRes-1:0]       res;
  } grp_t;

  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
    return v;
  endfunction

  // {valid, value}
  function automatic logic [8:0] esc_val(logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  function automatic grp_t grp_push(grp_t g, kind_e k, logic [7:0] d);
    grp_t r;
    r = g;
    if (g.cnt < CntW'(MaxRes)) begin
      r.res[g.cnt[IdxW-1:0]].kind = k;
      r.res[g.cnt[IdxW-1:0]].data = d;
      r.cnt = g.cnt + CntW'(1);
    end
    return r;
  endfunction

  function automatic grp_t grp_cp(grp_t g, logic [31:0] cp);
    grp_t r;
    r = g;
    if (cp < 32'h80) begin
      r = grp_push(r, KIND_BYTE, cp[7:0]);
    end else if (cp < 32'h800) begin
      r = grp_push(r, KIND_BYTE, 8'(32'hC0 | (cp >> 6)));
      r = grp_push(r, KIND_BYTE, 8'(32'h80 | (cp & 32'h3F)));
    end else if (cp < 32'h10000) begin
      r = grp_push(r, KIND_BYTE, 8'(32'hE0 | (cp >> 12)));
      r = grp_push(r, KIND_BYTE, 8'(32'h80 | ((cp >> 6) & 32'h3F)));
      r = grp_push(r, KIND_BYTE, 8'(32'h80 | (cp & 32'h3F)));
    end else begin
      r = grp_push(r, KIND_BYTE, 8'(32'hF0 | (cp >> 18)));
      r = grp_push(r, KIND_BYTE, 8'(32'h80 | ((cp >> 12) & 32'h3F)));
      r = grp_push(r, KIND_BYTE, 8'(32'h80 | ((cp >> 6) & 32'h3F)));
      r = grp_push(r, KIND_BYTE, 8'(32'h80 | (cp & 32'h3F)));
    end
    return r;
  endfunction

endpackage

@@ src/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode
// Parse state of the string decoder and the result group one text item makes.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    text_byte_i,
  input  logic          text_end_i,
  output jsu_pkg::grp_t grp_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     hcnt_q, hcnt_d;
  logic [15:0]    hacc_q, hacc_d;
  logic [15:0]    hi_q, hi_d;

  logic [4:0]     dig;
  logic [8:0]     esc;
  logic [15:0]    acc_new;
  logic [31:0]    pair_cp;
  jsu_pkg::grp_t  grp;

  assign dig     = jsu_pkg::hex_val(text_byte_i);
  assign esc     = jsu_pkg::esc_val(text_byte_i);
  assign acc_new = {hacc_q[11:0], dig[3:0]};
  assign pair_cp = 32'h10000 + (({16'h0, hi_q} - 32'hD800) << 10)
                 + ({16'h0, acc_new} - 32'hDC00);

  always_comb begin
    mode_d = mode_q;
    hcnt_d = hcnt_q;
    hacc_d = hacc_q;
    hi_d   = hi_q;
    grp    = '0;
    if (text_end_i) begin
      grp    = jsu_pkg::grp_push(grp, jsu_pkg::KIND_ERROR, 8'h00);
      mode_d = jsu_pkg::MODE_IDLE;
      hcnt_d = '0;
      hacc_d = '0;
      hi_d   = '0;
    end else begin
      unique case (mode_q) inside
        jsu_pkg::MODE_STRING, jsu_pkg::MODE_HI_WAIT: begin
          if (mode_q == jsu_pkg::MODE_HI_WAIT && text_byte_i == jsu_pkg::ChBslash) begin
            mode_d = jsu_pkg::MODE_HI_BSLASH;
          end else begin
            if (mode_q == jsu_pkg::MODE_HI_WAIT) begin
              grp  = jsu_pkg::grp_cp(grp, {16'h0, hi_q});
              hi_d = '0;
            end
            if (text_byte_i == jsu_pkg::ChQuote) begin
              grp    = jsu_pkg::grp_push(grp, jsu_pkg::KIND_DONE, 8'h00);
              mode_d = jsu_pkg::MODE_IDLE;
            end else if (text_byte_i == jsu_pkg::ChBslash) begin
              mode_d = jsu_pkg::MODE_ESCAPE;
            end else begin
              grp    = jsu_pkg::grp_push(grp, jsu_pkg::KIND_BYTE, text_byte_i);
              mode_d = jsu_pkg::MODE_STRING;
            end
          end
        end
        jsu_pkg::MODE_ESCAPE, jsu_pkg::MODE_HI_BSLASH: begin
          if (text_byte_i == jsu_pkg::ChU) begin
            mode_d = (mode_q == jsu_pkg::MODE_ESCAPE) ? jsu_pkg::MODE_HEX_FIRST
                                                      : jsu_pkg::MODE_HEX_LOW;
            hcnt_d = '0;
            hacc_d = '0;
          end else if (esc[8]) begin
            if (mode_q == jsu_pkg::MODE_HI_BSLASH) begin
              grp  = jsu_pkg::grp_cp(grp, {16'h0, hi_q});
              hi_d = '0;
            end
            grp    = jsu_pkg::grp_push(grp, jsu_pkg::KIND_BYTE, esc[7:0]);
            mode_d = jsu_pkg::MODE_STRING;
          end else begin
            grp    = jsu_pkg::grp_push(grp, jsu_pkg::KIND_ERROR, 8'h00);
            mode_d = jsu_pkg::MODE_IDLE;
            hcnt_d = '0;
            hacc_d = '0;
            hi_d   = '0;
          end
        end
        jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_LOW: begin
          if (dig[4]) begin
            grp    = jsu_pkg::grp_push(grp, jsu_pkg::KIND_ERROR, 8'h00);
            mode_d = jsu_pkg::MODE_IDLE;
            hcnt_d = '0;
            hacc_d = '0;
            hi_d   = '0;
          end else if (hcnt_q != 2'd3) begin
            hacc_d = acc_new;
            hcnt_d = hcnt_q + 2'd1;
          end else begin
            hcnt_d = '0;
            hacc_d = '0;
            if (mode_q == jsu_pkg::MODE_HEX_LOW) begin
              grp    = jsu_pkg::grp_cp(grp, pair_cp);
              hi_d   = '0;
              mode_d = jsu_pkg::MODE_STRING;
            end else if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
              hi_d   = acc_new;
              mode_d = jsu_pkg::MODE_HI_WAIT;
            end else begin
              grp    = jsu_pkg::grp_cp(grp, {16'h0, acc_new});
              mode_d = jsu_pkg::MODE_STRING;
            end
          end
        end
        default: begin
          if (text_byte_i == jsu_pkg::ChQuote) begin
            mode_d = jsu_pkg::MODE_STRING;
            hcnt_d = '0;
            hacc_d = '0;
            hi_d   = '0;
          end else begin
            grp    = jsu_pkg::grp_push(grp, jsu_pkg::KIND_ERROR, 8'h00);
            mode_d = jsu_pkg::MODE_IDLE;
            hcnt_d = '0;
            hacc_d = '0;
            hi_d   = '0;
          end
        end
      endcase
    end
  end

  assign grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_IDLE;
      hcnt_q <= '0;
      hacc_q <= '0;
      hi_q   <= '0;
    end else if (take_i) begin
      mode_q <= mode_d;
      hcnt_q <= hcnt_d;
      hacc_q <= hacc_d;
      hi_q   <= hi_d;
    end
  end

endmodule

@@ src/json_string_unescape_utf8.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming decoder for one JSON string literal, emitting UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input channel: one JSON text byte per item (text_byte_i), or an end-of-text
// marker (text_end_i), on in_valid_i / in_ready_o.
// Output channel: result items on out_valid_o / out_ready_i, each a decoded
// byte, a string-complete marker or an error; last_o flags the final result
// of one input item. An input item yields zero to four results.
// An item's results are registered when it is taken and shown once earlier
// groups are delivered. Throughput: one input item per cycle while in_ready_o
// is high; the output moves one result per cycle while out_ready_i is high.
// Results are held in a two-group queue, so a new item is taken while the
// previous group is still draining; in_ready_o drops only when both slots
// hold undelivered groups.
// Reset: parser returns to idle (awaiting the opening quote), queue empties.
// When the receiver stalls, the current result holds on the port and the
// input side stops once the queue is full.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int IdxW = jsu_pkg::IdxW;
  localparam int CntW = jsu_pkg::CntW;

  logic          take;
  logic          push;
  logic          pop;
  logic          fire;
  logic          last;
  jsu_pkg::grp_t grp;
  jsu_pkg::grp_t head;
  jsu_pkg::grp_t slot_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    fill_q;
  logic [IdxW-1:0] idx_q;

  assign take = in_valid_i && in_ready_o;

  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .text_byte_i (text_byte_i),
    .text_end_i  (text_end_i),
    .grp_o       (grp)
  );

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = take && (grp.cnt != '0);
  assign head       = slot_q[rd_q];
  assign out_valid_o = (fill_q != 2'd0);
  assign fire       = out_valid_o && out_ready_i;
  assign last       = ({1'b0, idx_q} == (head.cnt - CntW'(1)));
  assign pop        = fire && last;

  assign kind_o     = head.res[idx_q].kind;
  assign out_byte_o = head.res[idx_q].data;
  assign last_o     = last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
      idx_q  <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop)      fill_q <= fill_q + 2'd1;
      else if (pop && !push) fill_q <= fill_q - 2'd1;
      if (pop)       idx_q <= '0;
      else if (fire) idx_q <= idx_q + IdxW'(1);
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'd2)
    else $error("result queue overfilled");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head.cnt != '0))
    else $error("empty group in result queue");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, idx_q} < head.cnt))
    else $error("result index past group end");

  a_pop_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (idx_q == '0))
    else $error("result index not rewound after group");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Streams JSON text bytes into json_string_unescape_utf8 and checks every
// decoded UTF-8 byte, completion marker and error against a short directed
// table or a cycle-free decoder model. The table covers extremes and error
// paths, then random strings mix plain bytes, escapes, code units, surrogate
// pairs, broken sequences and noise, under bursty input and stalling output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDir     = 29;
  localparam int NRand    = 200;
  localparam int PauseAt  = NDir + 120;
  localparam int HoldAt   = NDir + 60;
  localparam int HoldLen  = 80;
  localparam int CycLimit = 400000;

  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} chk_e;

  typedef struct {
    logic [7:0]     b;
    logic           fin;
    chk_e           chk;
    jsu_pkg::kind_e kind;
    logic [7:0]     data;
  } row_t;

  typedef struct packed {
    jsu_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } decoded_t;

  localparam logic [7:0] EscLetters [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

  row_t dir_rows [NDir] = '{
    '{"x",   1'b0, CHK_ONE,  jsu_pkg::KIND_ERROR, 8'h00},
    '{8'hA5, 1'b1, CHK_ONE,  jsu_pkg::KIND_ERROR, 8'h00},
    '{"\"",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{8'h00, 1'b0, CHK_ONE,  jsu_pkg::KIND_BYTE,  8'h00},
    '{8'hFF, 1'b0, CHK_ONE,  jsu_pkg::KIND_BYTE,  8'hFF},
    '{"\\",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"q",   1'b0, CHK_ONE,  jsu_pkg::KIND_ERROR, 8'h00},
    '{"\"",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"\\",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"u",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"d",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"8",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"0",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"0",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"\\",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"t",   1'b0, CHK_PRED, jsu_pkg::KIND_BYTE,  8'h00},
    '{"\\",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"u",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"D",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"B",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"F",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"F",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"\\",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"u",   1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"g",   1'b0, CHK_ONE,  jsu_pkg::KIND_ERROR, 8'h00},
    '{"\"",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{"\"",  1'b0, CHK_ONE,  jsu_pkg::KIND_DONE,  8'h00},
    '{"\"",  1'b0, CHK_NONE, jsu_pkg::KIND_BYTE,  8'h00},
    '{8'h5A, 1'b1, CHK_ONE,  jsu_pkg::KIND_ERROR, 8'h00}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] text_byte_i = 8'h00;
  logic       text_end_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  json_string_unescape_utf8 uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .text_byte_i(text_byte_i),
    .text_end_i (text_end_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  row_t       text_q [$];
  decoded_t   decoded_q [$];
  decoded_t   step_res [$];

  jsu_pkg::mode_e parse_st = jsu_pkg::MODE_IDLE;
  logic [1:0]  hex_n    = 2'd0;
  logic [15:0] hex_acc  = 16'h0000;
  logic [15:0] hi_sur   = 16'h0000;

  int sent_n   = 0;
  int res_n    = 0;
  int fail_n   = 0;
  int done_n   = 0;
  int err_n    = 0;
  int pair_n   = 0;
  int cyc_n    = 0;

  function automatic logic [4:0] hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return 5'(b - "0");
    if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
    if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic esc_code(input logic [7:0] b, output logic [7:0] v);
    v = 8'h00;
    case (b)
      "\"", "\\", "/": v = b;
      "b": v = 8'h08;
      "f": v = 8'h0C;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void put_res(jsu_pkg::kind_e k, logic [7:0] d);
    decoded_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    if (step_res.size() < jsu_pkg::MaxRes) step_res.push_back(r);
  endfunction

  function automatic void put_cp(logic [31:0] cp);
    if (cp < 32'h80) begin
      put_res(jsu_pkg::KIND_BYTE, cp[7:0]);
    end else if (cp < 32'h800) begin
      put_res(jsu_pkg::KIND_BYTE, {3'b110, cp[10:6]});
      put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      put_res(jsu_pkg::KIND_BYTE, {4'hE, cp[15:12]});
      put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]});
      put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]});
    end else begin
      put_res(jsu_pkg::KIND_BYTE, {4'hF, cp[21:18]});
      put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[17:12]});
      put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]});
      put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]});
    end
  endfunction

  function automatic void abort_string();
    put_res(jsu_pkg::KIND_ERROR, 8'h00);
    err_n++;
    parse_st = jsu_pkg::MODE_IDLE;
    hex_n    = 2'd0;
    hex_acc  = 16'h0000;
    hi_sur   = 16'h0000;
  endfunction

  function automatic void string_byte(logic [7:0] b);
    if (b == jsu_pkg::ChQuote) begin
      put_res(jsu_pkg::KIND_DONE, 8'h00);
      done_n++;
      parse_st = jsu_pkg::MODE_IDLE;
    end else if (b == jsu_pkg::ChBslash) begin
      parse_st = jsu_pkg::MODE_ESCAPE;
    end else begin
      put_res(jsu_pkg::KIND_BYTE, b);
      parse_st = jsu_pkg::MODE_STRING;
    end
  endfunction

  // Advance the decoder by one text item and leave its results in step_res.
  function automatic void decode_item(logic [7:0] b, logic fin);
    logic [7:0]  v;
    logic [4:0]  d;
    logic [31:0] cp;
    step_res.delete();
    if (fin) begin
      abort_string();
    end else begin
      case (parse_st)
        jsu_pkg::MODE_STRING: string_byte(b);
        jsu_pkg::MODE_ESCAPE: begin
          if (b == jsu_pkg::ChU) begin
            parse_st = jsu_pkg::MODE_HEX_FIRST;
            hex_n    = 2'd0;
            hex_acc  = 16'h0000;
          end else if (esc_code(b, v)) begin
            put_res(jsu_pkg::KIND_BYTE, v);
            parse_st = jsu_pkg::MODE_STRING;
          end else begin
            abort_string();
          end
        end
        jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_LOW: begin
          d = hex_digit(b);
          if (d[4]) begin
            abort_string();
          end else begin
            hex_acc = {hex_acc[11:0], d[3:0]};
            if (hex_n != 2'd3) begin
              hex_n = hex_n + 2'd1;
            end else begin
              hex_n = 2'd0;
              if (parse_st == jsu_pkg::MODE_HEX_LOW) begin
                cp = 32'h10000 + (({16'h0, hi_sur} - 32'hD800) << 10)
                     + ({16'h0, hex_acc} - 32'hDC00);
                hi_sur = 16'h0000;
                put_cp(cp);
                pair_n++;
                parse_st = jsu_pkg::MODE_STRING;
              end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                hi_sur   = hex_acc;
                parse_st = jsu_pkg::MODE_HI_WAIT;
              end else begin
                put_cp({16'h0, hex_acc});
                parse_st = jsu_pkg::MODE_STRING;
              end
              hex_acc = 16'h0000;
            end
          end
        end
        jsu_pkg::MODE_HI_WAIT: begin
          if (b == jsu_pkg::ChBslash) begin
            parse_st = jsu_pkg::MODE_HI_BSLASH;
          end else begin
            put_cp({16'h0, hi_sur});
            hi_sur = 16'h0000;
            string_byte(b);
          end
        end
        jsu_pkg::MODE_HI_BSLASH: begin
          if (b == jsu_pkg::ChU) begin
            parse_st = jsu_pkg::MODE_HEX_LOW;
            hex_n    = 2'd0;
            hex_acc  = 16'h0000;
          end else if (esc_code(b, v)) begin
            put_cp({16'h0, hi_sur});
            hi_sur = 16'h0000;
            put_res(jsu_pkg::KIND_BYTE, v);
            parse_st = jsu_pkg::MODE_STRING;
          end else begin
            abort_string();
          end
        end
        default: begin
          if (b == jsu_pkg::ChQuote) begin
            parse_st = jsu_pkg::MODE_STRING;
            hex_n    = 2'd0;
            hex_acc  = 16'h0000;
            hi_sur   = 16'h0000;
          end else begin
            abort_string();
          end
        end
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_item(logic [7:0] b, logic fin);
    row_t r;
    r = '{b, fin, CHK_PRED, jsu_pkg::KIND_BYTE, 8'h00};
    text_q.push_back(r);
  endfunction

  // Emit the top k nibbles of v as hex characters of random case.
  function automatic void add_hex(logic [15:0] v, int k);
    logic [3:0] nib;
    logic [7:0] c;
    for (int i = 0; i < k; i++) begin
      nib = v[15 - 4 * i -: 4];
      if (nib < 4'd10) c = 8'h30 + 8'(nib);
      else c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
      add_item(c, 1'b0);
    end
  endfunction

  function automatic void add_unit(logic [15:0] cu);
    add_item(jsu_pkg::ChBslash, 1'b0);
    add_item(jsu_pkg::ChU, 1'b0);
    add_hex(cu, 4);
  endfunction

  function automatic void gen_text();
    int         n;
    int         sel;
    logic [7:0] b;
    logic [7:0] v;
    logic [15:0] cu;
    if ($urandom_range(0, 9) == 0) begin
      add_item(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
      return;
    end
    add_item(jsu_pkg::ChQuote, 1'b0);
    n = $urandom_range(0, 6);
    repeat (n) begin
      sel = $urandom_range(0, 19);
      if (sel < 7) begin
        b = 8'($urandom_range(0, 255));
        if (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBslash) b = b ^ 8'h01;
        add_item(b, 1'b0);
      end else if (sel < 10) begin
        add_item(jsu_pkg::ChBslash, 1'b0);
        add_item(EscLetters[$urandom_range(0, 7)], 1'b0);
      end else if (sel < 13) begin
        case ($urandom_range(0, 2))
          0:       cu = 16'($urandom_range(0, 16'h7F));
          1:       cu = 16'($urandom_range(16'h80, 16'h7FF));
          default: cu = 16'($urandom_range(16'h800, 16'hFFFF));
        endcase
        add_unit(cu);
      end else if (sel < 17) begin
        add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        if (sel < 16) begin
          if ($urandom_range(0, 3) == 0) cu = 16'($urandom_range(0, 16'hFFFF));
          else cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
          add_unit(cu);
        end
      end else if (sel == 17) begin
        case ($urandom_range(0, 3))
          0: begin
            add_item(jsu_pkg::ChBslash, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (esc_code(b, v) || b == jsu_pkg::ChU);
            add_item(b, 1'b0);
          end
          1: begin
            add_item(jsu_pkg::ChBslash, 1'b0);
            add_item(jsu_pkg::ChU, 1'b0);
            add_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
            do b = 8'($urandom_range(0, 255)); while (hex_digit(b) != 5'd16);
            add_item(b, 1'b0);
          end
          2: add_item(8'($urandom_range(0, 255)), 1'b1);
          default: begin
            add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            add_item(jsu_pkg::ChBslash, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (esc_code(b, v) || b == jsu_pkg::ChU);
            add_item(b, 1'b0);
          end
        endcase
        return;
      end else begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBslash) b = b + 8'd1;
        add_item(b, 1'b0);
      end
    end
    add_item(jsu_pkg::ChQuote, 1'b0);
  endfunction

  initial begin
    row_t it;
    int   burst;
    int   gap;
    foreach (dir_rows[i]) text_q.push_back(dir_rows[i]);
    while (text_q.size() < NDir + NRand) gen_text();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst = 0;
    for (int idx = 0; idx < text_q.size(); idx++) begin
      it = text_q[idx];
      if (idx == NDir || idx == PauseAt) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (decoded_q.size() != 0) @(posedge clk_i);
      end else if (burst == 0) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      if (burst > 0) burst--;
      in_valid_i  <= 1'b1;
      text_byte_i <= it.b;
      text_end_i  <= it.fin;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sent_n++;
      decode_item(it.b, it.fin);
      if (it.chk != CHK_PRED) step_res.delete();
      if (it.chk == CHK_ONE) put_res(it.kind, it.data);
      if (it.chk == CHK_ONE) step_res[0].last = 1'b1;
      foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    end
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d text items (%0d directed); checked %0d results.", sent_n, NDir, res_n);
    $display("Strings closed %0d, errors %0d, surrogate pairs joined %0d.",
             done_n, err_n, pair_n);
    if (fail_n == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int  seg;
    int  style;
    bit  held;
    held = 1'b0;
    forever begin
      if (!held && sent_n >= HoldAt) begin
        out_ready_i <= 1'b0;
        repeat (HoldLen) @(posedge clk_i);
        held = 1'b1;
      end
      style = $urandom_range(0, 2);
      seg   = $urandom_range(5, 40);
      repeat (seg) begin
        case (style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    decoded_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_n++;
      if (decoded_q.size() == 0) begin
        $display("%0t: expected no result, got kind %0d byte %02h last %0b",
                 $time, kind_o, out_byte_o, last_o);
        fail_n++;
      end else begin
        want = decoded_q.pop_front();
        if (kind_o !== want.kind || out_byte_o !== want.data || last_o !== want.last) begin
          $display("%0t: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                   $time, want.kind, want.data, want.last, kind_o, out_byte_o, last_o);
          fail_n++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_n++;
    if (cyc_n >= CycLimit) begin
      $display("Timeout after %0d cycles, %0d results still due", cyc_n, decoded_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
